/* rtl/uart_baud_divisor_calc_assert.svh */
// Assertion macros shared by the divisor calculator RTL.
`ifndef UART_BAUD_DIVISOR_CALC_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALC_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UBDC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UBDC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ubdc_pkg.sv */
// ----------------------------------------------------------------------------
// ubdc_pkg
// Widths, codes and stage types of the UART baud divisor calculator.
// ----------------------------------------------------------------------------
package ubdc_pkg;

   localparam int PORT_W  = 2;
   localparam int BAUD_W  = 24;
   localparam int CLOCK_W = 32;
   localparam int WORD_W  = 16;
   localparam int FRAC_W  = 4;

   // Dividend is 2*clock + baud, divisor is 2*baud
   localparam int NUM_W = CLOCK_W + 2;
   localparam int DEN_W = BAUD_W + 1;

   // One quotient bit per pipeline stage
   localparam int DIV_STEPS = NUM_W;

   localparam logic [PORT_W-1:0]  FULL_CLOCK_PORT  = 2'd1;
   localparam logic [CLOCK_W-1:0] CORE_CLOCK_RESET = 32'd72000000;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] work;
      logic [DEN_W-1:0] den;
      logic             zero;
   } div_work_type;

endpackage

/* rtl/ubdc_req_if.sv */
// ----------------------------------------------------------------------------
// ubdc_req_if
// Request channel: port number and baud rate with valid/ready.
// ----------------------------------------------------------------------------
interface ubdc_req_if;
   import ubdc_pkg::*;

   logic              valid;
   logic              ready;
   logic [PORT_W-1:0] port_number;
   logic [BAUD_W-1:0] baud_rate;

   modport source (output valid, output port_number, output baud_rate, input ready);
   modport sink   (input valid, input port_number, input baud_rate, output ready);

endinterface

/* rtl/ubdc_rsp_if.sv */
// ----------------------------------------------------------------------------
// ubdc_rsp_if
// Response channel: divisor word and range flag with valid/ready.
// ----------------------------------------------------------------------------
interface ubdc_rsp_if;
   import ubdc_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] divisor_word;
   logic              out_of_range;

   modport source (output valid, output divisor_word, output out_of_range, input ready);
   modport sink   (input valid, input divisor_word, input out_of_range, output ready);

endinterface

/* rtl/uart_baud_divisor_calc.sv */
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc
// UART 16x oversampling baud divisor calculator, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries a port number and a baud rate; rsp_chan returns the
//   16-bit divisor word (mantissa in 15:4, rounded fraction in 3:0) and an
//   out-of-range flag. csr_wr_en/csr_wr_data write the core clock in Hz;
//   port 1 divides the core clock, other ports divide half of it.
//   The divisor is computed as (2*clock + baud) / (2*baud), one quotient bit
//   per stage over 34 restoring division stages.
//   Stages: one operand stage, 34 division stages, one output register.
//   Throughput: one word per cycle unless the receiver stalls; the division stages set this figure.
//   Each stage has its own valid bit, so bubbles close up and the request
//   side keeps accepting while a response waits.
//   Reset clears all valid bits and loads a 72 MHz core clock.
//   When the receiver stalls, words hold in place and back up stage by stage
//   until req_chan.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "uart_baud_divisor_calc_assert.svh"

module uart_baud_divisor_calc (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   ubdc_req_if.sink    req_chan,
   ubdc_rsp_if.source  rsp_chan
);
   import ubdc_pkg::*;

   logic         stage_valid [DIV_STEPS+1];
   logic         stage_ready [DIV_STEPS+1];
   div_work_type stage_data  [DIV_STEPS+1];

   // Select clock and set up operands
   ubdc_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_chan),
      .out_valid   (stage_valid[0]),
      .out_ready   (stage_ready[0]),
      .out_data    (stage_data[0])
   );

   // Chain the division steps
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      ubdc_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   // Pack the word and check range
   ubdc_post u_post (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stage_valid[DIV_STEPS]),
      .in_ready (stage_ready[DIV_STEPS]),
      .in_data  (stage_data[DIV_STEPS]),
      .rsp      (rsp_chan)
   );

   // Checks
   `UBDC_ASSERT_NXT(a_accept_fills_prep, clock, reset, req_chan.valid && req_chan.ready, stage_valid[0], "accepted word did not reach the operand stage")
   `UBDC_ASSERT_IMP(a_ready_only_when_full, clock, reset, !req_chan.ready, stage_valid[0], "request stalled with an empty operand stage")
   `UBDC_ASSERT_IMP(a_zero_mantissa_flagged, clock, reset, rsp_chan.valid && !rsp_chan.out_of_range, rsp_chan.divisor_word[WORD_W-1:FRAC_W] != '0, "zero mantissa without range flag")
   `UBDC_ASSERT_IMP(a_zero_word_flagged, clock, reset, rsp_chan.valid && (rsp_chan.divisor_word == '0), rsp_chan.out_of_range, "zero divisor word without range flag")

endmodule

/* rtl/ubdc_prep.sv */
// ----------------------------------------------------------------------------
// ubdc_prep
// Clock register, port clock select and division operand setup stage.
// ----------------------------------------------------------------------------
module ubdc_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data,
   ubdc_req_if.sink              req,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ubdc_pkg::div_work_type out_data
);
   import ubdc_pkg::*;

   logic [CLOCK_W-1:0] core_clock_ff;
   logic [CLOCK_W-1:0] clock_sel;
   logic               valid_ff;
   div_work_type       data_ff;
   div_work_type       data_in;

   // Hold the core clock setting
   always_ff @(posedge clock) begin
      if (reset) begin
         core_clock_ff <= CORE_CLOCK_RESET;
      end else if (csr_wr_en) begin
         core_clock_ff <= csr_wr_data;
      end
   end

   // Pick the peripheral clock and form round-to-nearest operands
   always_comb begin
      clock_sel = (req.port_number == FULL_CLOCK_PORT) ? core_clock_ff
                                                        : (core_clock_ff >> 1);
      data_in.rem  = '0;
      data_in.work = {1'b0, clock_sel, 1'b0} + NUM_W'(req.baud_rate);
      data_in.den  = {req.baud_rate, 1'b0};
      data_in.zero = (req.baud_rate == '0);
   end

   assign req.ready = !valid_ff || out_ready;

   // Advance the stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/ubdc_div_stage.sv */
// ----------------------------------------------------------------------------
// ubdc_div_stage
// One restoring division step: retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module ubdc_div_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ubdc_pkg::div_work_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ubdc_pkg::div_work_type out_data
);
   import ubdc_pkg::*;

   logic [DEN_W:0] partial;
   logic [DEN_W:0] diff;
   logic           fits;
   logic           valid_ff;
   div_work_type   data_ff;
   div_work_type   data_in;

   // Shift in the next dividend bit and trial-subtract the divisor
   always_comb begin
      partial      = {in_data.rem, in_data.work[NUM_W-1]};
      diff         = partial - {1'b0, in_data.den};
      fits         = !diff[DEN_W];
      data_in.rem  = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
      data_in.work = {in_data.work[NUM_W-2:0], fits};
      data_in.den  = in_data.den;
      data_in.zero = in_data.zero;
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance when this stage is empty or the next stage takes its word
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* rtl/ubdc_post.sv */
// ----------------------------------------------------------------------------
// ubdc_post
// Output register: divisor word packing and range check.
// ----------------------------------------------------------------------------
module ubdc_post (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ubdc_pkg::div_work_type in_data,
   ubdc_rsp_if.source            rsp
);
   import ubdc_pkg::*;

   logic              valid_ff;
   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;
   logic              range_ff;
   logic              range_in;
   logic              mant_zero;
   logic              mant_wide;

   // Quotient is 16*mantissa + fraction with the rounding carry applied
   always_comb begin
      mant_zero = (in_data.work[NUM_W-1:FRAC_W] == '0);
      mant_wide = (in_data.work[NUM_W-1:WORD_W] != '0);
      word_in   = in_data.zero ? '0 : in_data.work[WORD_W-1:0];
      range_in  = in_data.zero || mant_zero || mant_wide;
   end

   assign in_ready = !valid_ff || rsp.ready;

   // Hold the word until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff  <= word_in;
         range_ff <= range_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.divisor_word = word_ff;
   assign rsp.out_of_range = range_ff;

endmodule

/* sim/uart_baud_divisor_calc_tb.sv */
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc_tb
// Self-checking bench for the UART baud divisor calculator. Each accepted
// request is run through a local divisor model and queued. Each accepted
// response word is compared against the oldest queued result. A directed set
// covers overflow, zero mantissa, zero baud, port zero, ties and fraction
// carry. Random phases then sweep several core clocks, including both
// extremes, under different sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc_tb;
   import ubdc_pkg::*;

   localparam int OVERSAMPLE      = 16;
   localparam int MANTISSA_MAX    = 4095;
   localparam int PIPE_LATENCY    = 36;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 244;
   localparam logic [BAUD_W-1:0] BAUD_MAX = '1;

   typedef struct packed {
      logic [WORD_W-1:0] divisor_word;
      logic              out_of_range;
   } divisor_result_type;

   // -------------------------------------------------------------------------
   // Divisor scoreboard: local model of the block plus queue of expected words
   // -------------------------------------------------------------------------
   class divisor_scoreboard;
      logic [CLOCK_W-1:0] core_clock_hz;
      divisor_result_type pending_divisors[$];
      int                 mismatch_count;

      function new();
         core_clock_hz  = CORE_CLOCK_RESET;
         mismatch_count = 0;
      endfunction

      function divisor_result_type compute_divisor(logic [PORT_W-1:0] port,
                                                   logic [BAUD_W-1:0] baud);
         bit [63:0]          clk_hz;
         bit [63:0]          den;
         bit [63:0]          mant;
         bit [63:0]          rem;
         bit [63:0]          frac;
         divisor_result_type res;
         // pick full or half clock; port zero counts as a slow port
         clk_hz = (port == FULL_CLOCK_PORT) ? 64'(core_clock_hz) : 64'(core_clock_hz >> 1);
         if (baud == 0) begin
            res.divisor_word = '0;
            res.out_of_range = 1'b1;
            return res;
         end
         den  = 64'(baud) * OVERSAMPLE;
         mant = clk_hz / den;
         rem  = clk_hz - mant * den;
         // round the fraction to nearest, halves up; carry a full fraction
         frac = (rem * OVERSAMPLE + den / 2) / den;
         if (frac == OVERSAMPLE) begin
            mant = mant + 1;
            frac = 0;
         end
         res.out_of_range = (mant == 0) || (mant > MANTISSA_MAX);
         res.divisor_word = {mant[WORD_W-FRAC_W-1:0], frac[FRAC_W-1:0]};
         return res;
      endfunction

      function void note_request(logic [PORT_W-1:0] port, logic [BAUD_W-1:0] baud);
         pending_divisors.push_back(compute_divisor(port, baud));
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatch_count++;
      endtask

      task check_response(logic [WORD_W-1:0] word, logic out_of_range);
         divisor_result_type exp_r;
         if (pending_divisors.size() == 0) begin
            report($sformatf("unexpected word %h flag %b", word, out_of_range));
         end else begin
            exp_r = pending_divisors.pop_front();
            if (word !== exp_r.divisor_word)
               report($sformatf("divisor_word %h, want %h", word, exp_r.divisor_word));
            if (out_of_range !== exp_r.out_of_range)
               report($sformatf("out_of_range %b, want %b", out_of_range,
                                exp_r.out_of_range));
         end
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [CLOCK_W-1:0] csr_wr_data;
   int                 sender_idle_pct;
   int                 receiver_stall_pct;
   int                 cycle_count;
   divisor_scoreboard  sb;

   ubdc_req_if req_chan();
   ubdc_rsp_if rsp_chan();

   uart_baud_divisor_calc u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Drop the run if it hangs
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: check each accepted word, then stall at random
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.divisor_word, rsp_chan.out_of_range);
         rsp_chan.ready <= !reset && ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Present one request, idling first at random, and hold until accepted
   task automatic send_request(logic [PORT_W-1:0] port, logic [BAUD_W-1:0] baud);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.port_number <= port;
      req_chan.baud_rate   <= baud;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(port, baud);
   endtask

   // Drop valid and wait until every queued word has come back
   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      while (sb.pending_divisors.size() != 0)
         @(posedge clock);
   endtask

   // Write the core clock register while the pipeline is empty
   task automatic set_core_clock(logic [CLOCK_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.core_clock_hz = value;
   endtask

   initial begin
      logic [CLOCK_W-1:0] phase_clock;
      logic [PORT_W-1:0]  port;
      longint unsigned    eff_clock;
      longint unsigned    quot;
      longint unsigned    baud;
      int                 pick;

      sb = new();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.port_number <= '0;
      req_chan.baud_rate   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset clock of 72 MHz
      send_request(2'd1, 24'd1);           // mantissa far too large
      send_request(2'd2, 24'd1);
      send_request(2'd3, 24'd1);
      send_request(2'd0, 24'd1);           // port zero runs at half clock
      send_request(2'd1, BAUD_MAX);        // mantissa zero
      send_request(2'd0, BAUD_MAX);
      send_request(2'd1, 24'd0);           // zero baud, no division
      send_request(2'd2, 24'd0);
      send_request(2'd1, 24'd115200);
      send_request(2'd2, 24'd115200);
      send_request(2'd3, 24'd9600);
      send_request(2'd0, 24'd9600);
      send_request(2'd1, 24'd1098);        // just above the mantissa limit
      send_request(2'd1, 24'd1099);        // just below it
      send_request(2'd1, 24'd4500000);     // mantissa of one exactly
      send_request(2'd1, 24'd4500001);     // fraction carries up to one
      send_request(2'd1, 24'd640000);      // fraction tie rounds up
      send_request(2'd1, 24'd15360);       // tie rounds to a full carry
      send_request(2'd2, 24'd7680);        // same carry on a slow port
      send_request(2'd3, 24'd2250000);
      drain_pipeline();

      // Random phases: one clock setting and one idling pattern each
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: phase_clock = 32'd72000000;
            1: phase_clock = 32'd1;
            2: phase_clock = 32'hFFFF_FFFF;
            3: phase_clock = 32'd8000000;
            4: phase_clock = $urandom;
            5: phase_clock = 32'd16000000;
            6: phase_clock = $urandom_range(1000000, 200000000);
            default: phase_clock = 32'd36864000;
         endcase
         set_core_clock(phase_clock);
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
            default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            port = PORT_W'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            eff_clock = (port == FULL_CLOCK_PORT) ? 64'(phase_clock) : 64'(phase_clock >> 1);
            if (pick < 60) begin
               // aim at a mantissa around the usable range
               quot = eff_clock / 64'(OVERSAMPLE * $urandom_range(1, 4300));
               if (quot == 0)
                  baud = 64'($urandom_range(1, 16));
               else
                  baud = quot - 1 + 64'($urandom_range(0, 2));
               if (baud > 64'(BAUD_MAX))
                  baud = 64'(BAUD_MAX);
               if (baud == 0)
                  baud = 1;
            end else if (pick < 80) begin
               baud = 64'($urandom) & 64'(BAUD_MAX);
            end else if (pick < 96) begin
               baud = 64'($urandom_range(1, 5000));
            end else if (pick < 98) begin
               baud = 0;
            end else begin
               baud = 64'(BAUD_MAX);
            end
            send_request(port, baud[BAUD_W-1:0]);
         end
         drain_pipeline();
      end

      // Hold for stray words past the pipeline depth
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (sb.pending_divisors.size() != 0)
         sb.report($sformatf("%0d words never arrived", sb.pending_divisors.size()));
      if (sb.mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/ubdc_pkg.sv
rtl/ubdc_req_if.sv
rtl/ubdc_rsp_if.sv
rtl/ubdc_prep.sv
rtl/ubdc_div_stage.sv
rtl/ubdc_post.sv
rtl/uart_baud_divisor_calc.sv
sim/uart_baud_divisor_calc_tb.sv
